FILE: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CRBF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication that must hold even while reset is asserted.
`define CRBF_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: rtl/core/crbf_pkg.sv
// Package with payload types, constants and register codes of the RBF evaluator.
`default_nettype none
package crbf_pkg;
	localparam int unsigned MaxCentersDefault = 1024;
	localparam int unsigned CountWidth = 11;
	localparam int unsigned CfgIndexWidth = 3;
	localparam logic [CfgIndexWidth-1:0] RegNumCenters = 3'd0;
	localparam logic [CfgIndexWidth-1:0] RegPolyConst = 3'd1;
	localparam logic [CfgIndexWidth-1:0] RegPolyX = 3'd2;
	localparam logic [CfgIndexWidth-1:0] RegPolyY = 3'd3;
	localparam logic [CfgIndexWidth-1:0] RegPolyZ = 3'd4;
	localparam logic CmdLoad = 1'b0;
	localparam logic CmdQuery = 1'b1;
	localparam int unsigned EntryWidth = 16 + 16 + 16 + 32;

	typedef struct packed {
		logic command;
		logic [9:0] entry_index;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic signed [15:0] coord_z;
		logic signed [31:0] center_weight;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic saturated;
	} out_item_t;

	// Handshake between the sequencer and the distance/cube datapath.
	typedef struct packed {
		logic start;
		logic busy;
	} sqrt_ctl_t;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b, output logic ovf);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		ovf = (s[64] != s[63]);
		if (ovf)
			sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			sat_add64 = s[63:0];
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/crbf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module crbf_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/crbf_cube.sv
// Distance, bit-serial square root and cube of one center, weighted by its weight.
`default_nettype none
module crbf_cube import crbf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire sqrt_ctl_t ctl_in,
	input wire logic signed [15:0] px,
	input wire logic signed [15:0] py,
	input wire logic signed [15:0] pz,
	input wire logic [EntryWidth-1:0] entry,
	output sqrt_ctl_t ctl_out,
	output logic done,
	output logic signed [63:0] term,
	output logic term_sat
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StSqr = 3'd1;
	localparam logic [2:0] StSqrt = 3'd2;
	localparam logic [2:0] StCube1 = 3'd3;
	localparam logic [2:0] StCube2 = 3'd4;
	localparam logic [2:0] StMul = 3'd5;

	logic [2:0] state_q;
	logic signed [16:0] dx_q, dy_q, dz_q;
	logic signed [31:0] w_q;
	logic [35:0] dsq_q;
	logic [50:0] rem_q;
	logic [25:0] res_q;
	logic [4:0] cnt_q;
	logic [49:0] sq_q;
	logic [74:0] cu_q;
	logic [31:0] r3_q;
	logic sat_q;
	logic signed [63:0] term_q;
	logic done_q;
	logic [52:0] trial;
	logic [50:0] rem_sh;
	logic [24:0] r16;

	assign rem_sh = {rem_q[48:0], dsq_q[35:34]};
	assign trial = {2'b0, rem_sh} - {25'd0, res_q, 2'b01};
	assign r16 = res_q[24:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				StIdle: begin
					if (ctl_in.start)
						state_q <= StSqr;
				end
				StSqr: state_q <= StSqrt;
				StSqrt: begin
					if (cnt_q == 5'd0)
						state_q <= StCube1;
				end
				StCube1: state_q <= StCube2;
				StCube2: state_q <= StMul;
				StMul: begin
					state_q <= StIdle;
					done_q <= 1'b1;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// Datapath: dsq << 16 fits in 52 bits, so the root takes 26 steps of two bits.
	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				dx_q <= 17'(px) - 17'(signed'(entry[79:64]));
				dy_q <= 17'(py) - 17'(signed'(entry[63:48]));
				dz_q <= 17'(pz) - 17'(signed'(entry[47:32]));
				w_q <= signed'(entry[31:0]);
			end
			StSqr: begin
				dsq_q <= 36'(unsigned'(34'(dx_q * dx_q))) + 36'(unsigned'(34'(dy_q * dy_q)))
					+ 36'(unsigned'(34'(dz_q * dz_q)));
				rem_q <= '0;
				res_q <= '0;
				cnt_q <= 5'd25;
			end
			StSqrt: begin
				// Radicand dsq*2^16 is consumed two bits per step from the top.
				dsq_q <= {dsq_q[33:0], 2'b00};
				if (!trial[52]) begin
					rem_q <= trial[50:0];
					res_q <= {res_q[24:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					res_q <= {res_q[24:0], 1'b0};
				end
				if (cnt_q != 5'd0)
					cnt_q <= cnt_q - 5'd1;
			end
			StCube1: begin
				sat_q <= (res_q >= 26'd2097152);
				sq_q <= 50'(r16[20:0] * r16[20:0]);
			end
			StCube2: begin
				cu_q <= 75'(sq_q[41:0] * r16[20:0]);
			end
			StMul: begin
				if (sat_q || cu_q[74:32] > 43'h7FFFFFFF) begin
					term_q <= 64'(w_q) * 64'sd2147483647;
					r3_q <= 32'h7FFFFFFF;
					sat_q <= 1'b1;
				end else begin
					term_q <= 64'(w_q) * signed'({1'b0, cu_q[62:32]});
					r3_q <= cu_q[63:32];
				end
			end
			default: ;
		endcase
	end

	assign ctl_out.busy = (state_q != StIdle);
	assign ctl_out.start = done_q;
	assign done = done_q;
	assign term = term_q;
	assign term_sat = sat_q & (r3_q == 32'h7FFFFFFF);
endmodule
`default_nettype wire

FILE: rtl/core/cubic_rbf_evaluator_unit.sv
// One item is handled at a time; the per-center time is set by the 26-step square root.
// Reset clears control state and the five registers; the center memory is not cleared.
// Memory: one 80-bit wide RAM holds x, y, z and weight of each center.
`default_nettype none
module cubic_rbf_evaluator_unit import crbf_pkg::*; #(
	parameter int unsigned MaxCenters = MaxCentersDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CfgIndexWidth-1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int unsigned AddrWidth = (MaxCenters > 1) ? $clog2(MaxCenters) : 1;
	localparam int unsigned RamDepth = 1 << AddrWidth;
	localparam int unsigned CntW = AddrWidth + 1;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StRead = 3'd1;
	localparam logic [2:0] StWait = 3'd2;
	localparam logic [2:0] StPoly = 3'd3;
	localparam logic [2:0] StPolyAdd = 3'd4;
	localparam logic [2:0] StOut = 3'd5;

	logic [2:0] state_q;
	logic [CountWidth-1:0] num_centers_q;
	logic signed [31:0] poly_const_q, poly_x_q, poly_y_q, poly_z_q;
	logic signed [15:0] px_q, py_q, pz_q;
	logic [CntW-1:0] idx_q, count_q;
	logic signed [63:0] acc_q;
	logic flag_q;
	logic [1:0] poly_q;
	logic signed [63:0] pterm_q;
	out_item_t out_q;
	logic out_valid_q;

	logic in_fire;
	logic we;
	logic [AddrWidth-1:0] waddr;
	logic [EntryWidth-1:0] rdata;
	sqrt_ctl_t ctl_to, ctl_from;
	logic done;
	logic signed [63:0] term;
	logic term_sat;
	logic signed [63:0] add_res;
	logic add_ovf;
	logic signed [63:0] add_b;
	logic [CntW-1:0] count_lim;

	// The block takes a request only in idle and only when the output slot is free.
	assign in_ready = (state_q == StIdle) && !out_valid_q;
	assign in_fire = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Loads beyond the table are dropped.
	assign we = in_fire && (in_data.command == CmdLoad)
		&& (32'(in_data.entry_index) < 32'(MaxCenters));
	assign waddr = AddrWidth'(in_data.entry_index);

	crbf_ram #(.Width(EntryWidth), .Depth(RamDepth)) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata({in_data.coord_x, in_data.coord_y, in_data.coord_z, in_data.center_weight}),
		.raddr(idx_q[AddrWidth-1:0]),
		.rdata(rdata)
	);

	assign ctl_to.start = (state_q == StWait) && !ctl_from.busy && !done;
	assign ctl_to.busy = 1'b0;

	crbf_cube u_cube (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_in(ctl_to),
		.px(px_q),
		.py(py_q),
		.pz(pz_q),
		.entry(rdata),
		.ctl_out(ctl_from),
		.done(done),
		.term(term),
		.term_sat(term_sat)
	);

	assign count_lim = (32'(num_centers_q) > 32'(MaxCenters)) ? CntW'(MaxCenters)
		: CntW'(num_centers_q);
	assign add_b = (state_q == StPolyAdd) ? pterm_q : term;
	always_comb add_res = sat_add64(acc_q, add_b, add_ovf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_centers_q <= '0;
			poly_const_q <= '0;
			poly_x_q <= '0;
			poly_y_q <= '0;
			poly_z_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegNumCenters: num_centers_q <= cfg_data[CountWidth-1:0];
				RegPolyConst: poly_const_q <= cfg_data;
				RegPolyX: poly_x_q <= cfg_data;
				RegPolyY: poly_y_q <= cfg_data;
				RegPolyZ: poly_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: walk centers one by one, then add the four polynomial terms.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			count_q <= '0;
			poly_q <= '0;
			flag_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				StIdle: begin
					if (in_fire && in_data.command == CmdQuery) begin
						px_q <= in_data.coord_x;
						py_q <= in_data.coord_y;
						pz_q <= in_data.coord_z;
						acc_q <= '0;
						flag_q <= 1'b0;
						idx_q <= '0;
						count_q <= count_lim;
						poly_q <= '0;
						state_q <= (count_lim == '0) ? StPoly : StRead;
					end
				end
				StRead: state_q <= StWait;
				StWait: begin
					if (done) begin
						acc_q <= add_res;
						flag_q <= flag_q | add_ovf | term_sat;
						if (idx_q + CntW'(1) == count_q) begin
							state_q <= StPoly;
						end else begin
							idx_q <= idx_q + CntW'(1);
							state_q <= StRead;
						end
					end
				end
				StPoly: begin
					case (poly_q)
						2'd0: pterm_q <= 64'(poly_const_q) <<< 16;
						2'd1: pterm_q <= (64'(poly_x_q) * 64'(px_q)) <<< 8;
						2'd2: pterm_q <= (64'(poly_y_q) * 64'(py_q)) <<< 8;
						default: pterm_q <= (64'(poly_z_q) * 64'(pz_q)) <<< 8;
					endcase
					state_q <= StPolyAdd;
				end
				StPolyAdd: begin
					acc_q <= add_res;
					flag_q <= flag_q | add_ovf;
					poly_q <= poly_q + 2'd1;
					state_q <= (poly_q == 2'd3) ? StOut : StPoly;
				end
				StOut: begin
					out_q.value <= acc_q;
					out_q.saturated <= flag_q;
					out_valid_q <= 1'b1;
					state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule
`default_nettype wire

FILE: rtl/core/crbf_checker.sv
// Port-level checker for the RBF evaluator and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module crbf_checker import crbf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire in_item_t in_data,
	input wire logic out_valid,
	input wire logic out_ready
);
	`CRBF_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped")
	`CRBF_ASSERT(a_no_accept_full, clk, arst_n, out_valid |-> !in_ready, "accepted while full")
	`CRBF_ASSERT(a_query_busy, clk, arst_n, in_valid && in_ready && in_data.command |=> !in_ready, "query not blocking")
	`CRBF_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !out_valid, "output valid in reset")
endmodule
bind cubic_rbf_evaluator_unit crbf_checker u_crbf_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready)
);
`default_nettype wire
